FILE: rtl/bmh_pkg.sv
// shared constants, request codes and the result word type of the max-heap engine
// no dependencies; imported by bmh_ctrl, the top level and the sim modules, not by bmh_ram
package bmh_pkg;

  // parameter defaults
  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed field widths on the stream ports
  localparam int KEY_IO_W   = 32;
  localparam int COUNT_IO_W = 9;
  localparam int REQ_W      = 2;
  localparam int MDATA_W    = 48;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // one finished result word
  typedef struct packed {
    logic [KEY_IO_W-1:0]   key;
    logic                  found;
    logic [COUNT_IO_W-1:0] count;
  } res_t;

endpackage

FILE: rtl/bmh_ram.sv
// generic simple dual-port ram: one write port, one read port with registered read data
// depends on nothing but width and depth parameters
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/bmh_ctrl.sv
// request sequencer of the max-heap engine: load, bottom-up build and pop with sift-down
// depends on bmh_pkg; drives the ports of one bmh_ram instance
module bmh_ctrl
  import bmh_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request side
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [REQ_W-1:0]            in_req,
  input  logic [KEY_IO_W-1:0]         in_key,
  // result side
  input  logic                        out_free,
  output logic                        res_push,
  output res_t                        res,
  // key memory
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [KEY_WIDTH-1:0]        wr_data,
  output logic                        rd_en,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [KEY_WIDTH-1:0]        rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_ROOT,
    S_POP_LAST,
    S_BLD_RD,
    S_BLD_TOP,
    S_SIFT_L,
    S_SIFT_R,
    S_SIFT_CMP,
    S_SIFT_END,
    S_DONE
  } state_t;

  state_t               state;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        n;
  logic [AW-1:0]        top;
  logic [AW-1:0]        par;
  logic [KEY_WIDTH-1:0] cur;
  logic [KEY_WIDTH-1:0] lkey;
  logic                 has_right;
  logic                 is_build;
  logic [KEY_WIDTH-1:0] res_key;
  logic                 res_found;

  logic                     in_fire;
  logic [KEY_WIDTH+31:0]    key_wide;
  logic [KEY_WIDTH-1:0]     load_key;
  logic                     not_full;
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            half_m1;
  logic [LW-1:0]            left_w;
  logic [LW-1:0]            right_w;
  logic [LW-1:0]            n_w;
  logic                     has_left;
  logic                     right_in;
  logic                     pick_right;
  logic [KEY_WIDTH-1:0]     pick_key;
  logic [AW-1:0]            pick_idx;
  logic                     stop;
  logic [KEY_WIDTH+31:0]    out_key_wide;
  logic [CW+8:0]            cnt_wide;

  // handshake and key sizing
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign key_wide = {{KEY_WIDTH{1'b0}}, in_key};
  assign load_key = key_wide[KEY_WIDTH-1:0];
  assign not_full = (cnt < CW'(CAPACITY));
  assign cnt_m1   = cnt - CW'(1);
  assign half_m1  = (cnt >> 1) - CW'(1);

  // child indices of the current hole
  assign left_w   = {1'b0, top, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign n_w      = LW'(n);
  assign has_left = (left_w < n_w);
  assign right_in = (right_w < n_w);

  // larger child, left on a tie, and the stop test
  assign pick_right = has_right && (lkey < rd_data);
  assign pick_key   = pick_right ? rd_data : lkey;
  assign pick_idx   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign stop       = (cur >= pick_key);

  // memory access per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = top;
    wr_data = cur;
    case (state)
      S_IDLE: begin
        if (in_fire && in_req == REQ_LOAD && not_full) begin
          wr_en   = 1'b1;
          wr_addr = cnt[AW-1:0];
          wr_data = load_key;
        end
        if (in_fire && in_req == REQ_POP && cnt != '0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_POP_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
      end
      S_BLD_RD: begin
        rd_en   = 1'b1;
        rd_addr = par;
      end
      S_SIFT_L: begin
        rd_en   = has_left;
        rd_addr = left_w[AW-1:0];
      end
      S_SIFT_R: begin
        rd_en   = right_in;
        rd_addr = right_w[AW-1:0];
      end
      S_SIFT_CMP: begin
        wr_en   = !stop;
        wr_data = pick_key;
      end
      S_SIFT_END: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_key   <= '0;
            res_found <= 1'b0;
            is_build  <= 1'b0;
            state     <= S_DONE;
            case (in_req)
              REQ_LOAD: begin
                if (not_full) begin
                  cnt       <= cnt + CW'(1);
                  res_found <= 1'b1;
                end
              end
              REQ_BUILD: begin
                if (cnt >= CW'(2)) begin
                  par      <= half_m1[AW-1:0];
                  n        <= cnt;
                  is_build <= 1'b1;
                  state    <= S_BLD_RD;
                end
              end
              REQ_POP: begin
                if (cnt != '0) begin
                  state <= S_POP_ROOT;
                end
              end
              default: ;
            endcase
          end
        end
        S_POP_ROOT: begin
          res_key   <= rd_data;
          res_found <= 1'b1;
          cnt       <= cnt_m1;
          n         <= cnt_m1;
          state     <= S_POP_LAST;
        end
        S_POP_LAST: begin
          cur   <= rd_data;
          top   <= '0;
          state <= S_SIFT_L;
        end
        S_BLD_RD: begin
          state <= S_BLD_TOP;
        end
        S_BLD_TOP: begin
          cur   <= rd_data;
          top   <= par;
          state <= S_SIFT_L;
        end
        S_SIFT_L: begin
          state <= has_left ? S_SIFT_R : S_SIFT_END;
        end
        S_SIFT_R: begin
          lkey      <= rd_data;
          has_right <= right_in;
          state     <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (stop) begin
            state <= S_SIFT_END;
          end else begin
            top   <= pick_idx;
            state <= S_SIFT_L;
          end
        end
        S_SIFT_END: begin
          if (is_build && par != '0) begin
            par   <= par - AW'(1);
            state <= S_BLD_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // result word
  assign out_key_wide = {32'd0, res_key};
  assign cnt_wide     = {9'd0, cnt};
  assign res_push     = (state == S_DONE) && out_free;
  assign res.key      = out_key_wide[KEY_IO_W-1:0];
  assign res.found    = res_found;
  assign res.count    = cnt_wide[COUNT_IO_W-1:0];

  // no read and write of the same slot in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same slot");

  // only held slots are ever read
  a_read_held: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CW'(rd_addr) < cnt))
    else $error("read of a slot above the entry count");

  // entry count stays within capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted load grows the heap by one
  a_load_inc: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_req == REQ_LOAD && not_full) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("load did not advance the entry count");

endmodule

FILE: rtl/binary_max_heap_engine.sv
// Binary max-heap engine on a stream interface. Each input word is one request (load, build,
// pop) and gives exactly one result word with the popped key, a found flag and the entry
// count. Keys live in one single-read-port memory, so each sift level goes through a left
// read, a right read, and a compare with write back. A pop moves the last leaf to the root
// and sinks it until it ends on a slot with no child or a compare stops it, up to log2 of
// the entry count levels; a build sinks each of the count/2 parents in turn on the same
// rule. Unused request code three and requests that find nothing to do still give a result.
// A new request is taken while the previous result waits in the output register.
// Top level; depends on bmh_pkg, bmh_ctrl and bmh_ram.
module binary_max_heap_engine
  import bmh_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // key_in[31:0]
  input  logic [1:0]         s_tuser,   // req_type[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,   // key_out[31:0], entry_count[40:32], zero pad
  output logic [0:0]         m_tuser    // found[0]
);

  localparam int AW = $clog2(CAPACITY);

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 out_free;
  logic                 res_push;
  res_t                 res;
  res_t                 out_res;

  // request sequencer
  bmh_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_req   (s_tuser),
    .in_key   (s_tdata),
    .out_free (out_free),
    .res_push (res_push),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // key memory
  bmh_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  // output word packing
  assign m_tdata = {{(MDATA_W - KEY_IO_W - COUNT_IO_W){1'b0}}, out_res.count, out_res.key};
  assign m_tuser = out_res.found;

endmodule

FILE: sim/bmh_heap_checker.sv
// Watches both stream channels of the max-heap engine, predicts each result word and compares it
// Depends on bmh_pkg for the request codes, the result word type and the default capacity
`timescale 1ns / 1ps

module bmh_heap_checker
  import bmh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [31:0]        s_tdata,   // key_in[31:0]
  input  logic [1:0]         s_tuser,   // req_type[1:0]
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [MDATA_W-1:0] m_tdata,   // key_out[31:0], entry_count[40:32], zero pad
  input  logic [0:0]         m_tuser,   // found[0]
  output int                 mismatch_count,
  output int                 results_owed
);

  localparam int HEAP_SLOTS = CAPACITY_DEF;

  // shadow copy of the heap array and its fill level
  logic [KEY_IO_W-1:0] heap_keys [HEAP_SLOTS];
  int unsigned         keys_held;
  res_t                heap_results_q [$];
  res_t                owed;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] heap result mismatch on %s: got %0h, want %0h", $realtime, what, got,
             want);
    mismatch_count++;
  endtask

  // push the key at slot top down until neither child is larger, left child wins a tie
  function automatic void sink_key(input int unsigned top, input int unsigned n);
    int unsigned         child;
    logic [KEY_IO_W-1:0] held_key;
    child = 2 * top + 1;
    while (child < n) begin
      if (child + 1 < n && heap_keys[child] < heap_keys[child + 1])
        child++;
      if (heap_keys[top] >= heap_keys[child])
        break;
      held_key         = heap_keys[top];
      heap_keys[top]   = heap_keys[child];
      heap_keys[child] = held_key;
      top   = child;
      child = 2 * top + 1;
    end
  endfunction

  // apply one request to the shadow heap and work out its result word
  task automatic heap_request(input logic [1:0] req, input logic [31:0] key, output res_t r);
    int unsigned p;
    r = '0;
    case (req)
      REQ_LOAD: begin
        if (keys_held < HEAP_SLOTS) begin
          heap_keys[keys_held] = key;
          keys_held++;
          r.found = 1'b1;
        end
      end
      REQ_BUILD: begin
        if (keys_held >= 2)
          for (p = keys_held / 2; p > 0; p--)
            sink_key(p - 1, keys_held);
      end
      REQ_POP: begin
        if (keys_held > 0) begin
          r.key = heap_keys[0];
          keys_held--;
          heap_keys[0] = heap_keys[keys_held];
          sink_key(0, keys_held);
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = keys_held[COUNT_IO_W-1:0];
  endtask

  // compare each result word with the oldest prediction, then predict for the accepted request
  always @(posedge clk) begin
    if (rst) begin
      keys_held = 0;
      heap_results_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (heap_results_q.size() == 0) begin
          report_mismatch("word with no request outstanding", 64'(m_tdata), '0);
        end else begin
          owed = heap_results_q.pop_front();
          if (m_tdata[31:0] !== owed.key)
            report_mismatch("key_out", 64'(m_tdata[31:0]), 64'(owed.key));
          if (m_tuser[0] !== owed.found)
            report_mismatch("found", 64'(m_tuser[0]), 64'(owed.found));
          if (m_tdata[40:32] !== owed.count)
            report_mismatch("entry_count", 64'(m_tdata[40:32]), 64'(owed.count));
        end
      end
      if (s_tvalid && s_tready) begin
        heap_request(s_tuser, s_tdata, owed);
        heap_results_q.push_back(owed);
      end
    end
    results_owed <= heap_results_q.size();
  end

endmodule

FILE: sim/binary_max_heap_engine_test.sv
// Top of the max-heap engine test: clock, reset, request stimulus, back pressure and verdict
// Depends on bmh_pkg, binary_max_heap_engine and bmh_heap_checker
`timescale 1ns / 1ps

module binary_max_heap_engine_test;
  import bmh_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;
  logic [1:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [MDATA_W-1:0] m_tdata;
  logic [0:0]         m_tuser;

  int mismatch_count;
  int results_owed;
  int sender_idle = 0;
  int receiver_stall = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int phase_end;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_max_heap_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bmh_heap_checker heap_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // receiver back pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall);
  end

  // hard stop for a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one request word, with random sender gaps ahead of it
  task automatic send_word(input logic [1:0] req, input logic [31:0] key);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // hold the sender off until every result word is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // keys: full range, a narrow range full of ties, or extremes
  function automatic logic [31:0] pick_key(input int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(7);
      default: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hffff_ffff;
          default: return $urandom & 32'hffff_0000;
        endcase
      end
    endcase
  endfunction

  // one run of requests: mostly load, build, pop to empty; some out of order; some noise
  task automatic run_heap_sequence();
    int choice;
    int n;
    int style;
    choice = $urandom_range(99);
    style  = $urandom_range(2);
    if (choice < 70) begin
      // occasionally fill past capacity
      n = ($urandom_range(29) == 0) ? $urandom_range(200, 262) : $urandom_range(1, 24);
      repeat (n) send_word(REQ_LOAD, pick_key(style));
      send_word(REQ_BUILD, $urandom);
      // appended keys after a build, sometimes rebuilt
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(REQ_LOAD, pick_key(style));
        if ($urandom_range(1))
          send_word(REQ_BUILD, $urandom);
      end
      repeat (n + $urandom_range(0, 6)) send_word(REQ_POP, $urandom);
    end else if (choice < 85) begin
      // pops on an array that was never heapified
      n = $urandom_range(1, 16);
      repeat (n) send_word(REQ_LOAD, pick_key(style));
      repeat ($urandom_range(0, n)) send_word(REQ_POP, $urandom);
      if ($urandom_range(1))
        send_word(REQ_BUILD, $urandom);
      repeat ($urandom_range(0, n)) send_word(REQ_POP, $urandom);
    end else begin
      repeat ($urandom_range(1, 12))
        send_word(REQ_W'($urandom_range(3)), pick_key($urandom_range(2)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty heap: pop, build and the unused code
    send_word(REQ_POP, 32'hffff_ffff);
    send_word(REQ_BUILD, 32'h0000_0000);
    send_word(REQ_UNUSED, 32'h5a5a_5a5a);
    // build with one key reorders nothing
    send_word(REQ_LOAD, 32'h0000_0000);
    send_word(REQ_BUILD, 32'h0000_0000);
    send_word(REQ_POP, 32'h0000_0000);
    // extreme keys
    send_word(REQ_LOAD, 32'hffff_ffff);
    send_word(REQ_LOAD, 32'h0000_0000);
    send_word(REQ_LOAD, 32'h8000_0000);
    send_word(REQ_LOAD, 32'h7fff_ffff);
    send_word(REQ_BUILD, 32'hffff_ffff);
    send_word(REQ_POP, 32'h0000_0000);
    // load after build lands unsorted at the tail
    send_word(REQ_LOAD, 32'hffff_ffff);
    send_word(REQ_LOAD, 32'h5555_5555);
    send_word(REQ_LOAD, 32'haaaa_aaaa);
    send_word(REQ_UNUSED, 32'hffff_ffff);
    send_word(REQ_POP, 32'h0000_0000);
    send_word(REQ_BUILD, 32'h0000_0000);
    // equal children
    send_word(REQ_LOAD, 32'h0000_0003);
    send_word(REQ_LOAD, 32'h0000_0003);
    send_word(REQ_BUILD, 32'h0000_0000);
    repeat (8) send_word(REQ_POP, 32'h0000_0000);
    drain_results();

    // random runs, cycling through the idling modes
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 66; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 66; end
        default: begin sender_idle = 36; receiver_stall = 36; end
      endcase
      phase_end = 30 + (phase + 1) * 240;
      while (words_sent < phase_end)
        run_heap_sequence();
      drain_results();
    end

    // settle time for any stray word
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
